>>> sv/imu_motion_metric_macros.svh
// ----------------------------------------------------------------------------
// imu motion metric assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef IMU_MOTION_METRIC_MACROS_SVH
`define IMU_MOTION_METRIC_MACROS_SVH

// checked only outside reset
`define IMM_ASSERT_RUN(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define IMM_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> sv/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// widths and constants of the imu motion metric block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int METRIC_W    = 56;
    localparam int MUL_A_W     = 96;
    localparam int MUL_B_W     = 48;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W   = 6;
    localparam int GYRO_COUNTS = 131;

    localparam logic [15:0]        GAIN_RESET = 16'd58982;
    localparam logic signed [23:0] Z_REF      = 24'sd642253;
    localparam logic [METRIC_W-1:0] METRIC_MAX = {METRIC_W{1'b1}};

    localparam logic [6:0] DIV_SMALL_STEPS = 7'd30;
    localparam logic [6:0] DIV_BIG_STEPS   = 7'd80;
    localparam logic [6:0] SQRT_STEPS      = 7'd25;

    localparam logic REG_GAIN = 1'b0;

endpackage

>>> sv/imm_smul.sv
// ----------------------------------------------------------------------------
// imm_smul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imm_smul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [imm_pkg::MUL_A_W-1:0]   a,
    input  logic [imm_pkg::MUL_B_W-1:0]   b,
    output logic                          busy,
    output logic [imm_pkg::MUL_P_W-1:0]   p
);

    localparam int AW = imm_pkg::MUL_A_W;
    localparam int BW = imm_pkg::MUL_B_W;
    localparam int PW = imm_pkg::MUL_P_W;
    localparam int CW = imm_pkg::MUL_CNT_W;

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] a_reg, a_next;
    logic [PW-1:0] p_reg, p_next;
    logic [AW:0]   sum;

    always_comb begin
        sum       = {1'b0, p_reg[PW-1:BW]} + (p_reg[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        p_next    = p_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(BW);
            a_next    = a;
            p_next    = {{AW{1'b0}}, b};
        end else if (busy_reg) begin
            p_next   = {sum, p_reg[BW-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        a_reg <= a_next;
        p_reg <= p_next;
    end

    assign busy = busy_reg;
    assign p    = p_reg;

endmodule

>>> sv/imu_motion_metric.sv
// ----------------------------------------------------------------------------
// imu_motion_metric
// offset calibration, low-pass residual and serial metric of one imu sample
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata: six 16-bit axis counts
//  m_       out  m_tvalid/m_tready  m_tdata: metric, m_tuser: saturated
//  apb      in   psel/penable       register 0: low-pass gain
//
//  calibration items are summed as they are accepted and give no item out
//  after calibration an item runs two 30-step divides and one product per axis,
//  ten more products, a 25-step root and an 80-step divide
//  every product runs in the shared bit-serial multiplier
//  one item at a time; a held result does not block the next item's input
//  reset is synchronous on aresetn and restores gain and calibration state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_motion_metric #(
    parameter int CALIB_SAMPLES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,   // motion_metric
    output logic         m_tuser,   // metric_saturated
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic signed [8:0] N_S    = 9'(CALIB_SAMPLES);
    localparam logic [6:0]        CAL_N  = 7'(CALIB_SAMPLES);
    localparam logic [29:0]       HALF_N = 30'(CALIB_SAMPLES / 2);
    localparam logic [51:0]       DEN_N  = 52'(CALIB_SAMPLES);
    localparam logic [51:0]       DEN_G  = 52'(imm_pkg::GYRO_COUNTS * CALIB_SAMPLES);
    localparam logic [29:0]       HALF_G = 30'((imm_pkg::GYRO_COUNTS * CALIB_SAMPLES) / 2);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_ASET  = 14'b00000000000010,
        ST_ADIV  = 14'b00000000000100,
        ST_GSET  = 14'b00000000001000,
        ST_GDIV  = 14'b00000000010000,
        ST_LPSET = 14'b00000000100000,
        ST_LPMUL = 14'b00000001000000,
        ST_LPR   = 14'b00000010000000,
        ST_NET   = 14'b00000100000000,
        ST_MSET  = 14'b00001000000000,
        ST_MWAIT = 14'b00010000000000,
        ST_SQRT  = 14'b00100000000000,
        ST_BDIV  = 14'b01000000000000,
        ST_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]        gain_reg, gain_next;
    logic [6:0]         calib_reg, calib_next;
    logic signed [23:0] asum_reg [3], asum_next [3];
    logic signed [23:0] gsum_reg [3], gsum_next [3];
    logic signed [23:0] lp_reg [3], lp_next [3];
    logic signed [15:0] a_reg [3], a_next [3];
    logic signed [15:0] g_reg [3], g_next [3];
    logic signed [23:0] acc_reg [3], acc_next [3];
    logic [8:0]         gmag_reg [3], gmag_next [3];
    logic [23:0]        netm_reg [3], netm_next [3];
    logic [1:0]         ax_reg, ax_next;
    logic               dsign_reg, dsign_next;
    logic               sgn_reg, sgn_next;
    logic [79:0]        dvd_reg, dvd_next;
    logic [51:0]        rem_reg, rem_next;
    logic [51:0]        den_reg, den_next;
    logic [55:0]        quo_reg, quo_next;
    logic               qsat_reg, qsat_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic signed [41:0] v_reg, v_next;
    logic signed [23:0] lpn_reg, lpn_next;
    logic [3:0]         mstep_reg, mstep_next;
    logic [47:0]        sq_reg, sq_next;
    logic [17:0]        t_reg, t_next;
    logic [26:0]        d_reg, d_next;
    logic [47:0]        y2_reg, y2_next;
    logic [95:0]        y4_reg, y4_next;
    logic [49:0]        sqv_reg, sqv_next;
    logic [26:0]        srem_reg, srem_next;
    logic [24:0]        root_reg, root_next;
    logic               mvalid_reg, mvalid_next;
    logic [55:0]        mdata_reg, mdata_next;
    logic               muser_reg, muser_next;

    logic               mul_start, mul_busy;
    logic [95:0]        mul_a;
    logic [47:0]        mul_b;
    logic [143:0]       mul_p;

    logic signed [15:0] a_sel, g_sel;
    logic signed [23:0] asum_sel, gsum_sel, acc_sel, lp_sel;
    logic signed [24:0] aprod, gprod, adiff, gdiff, ldiff, net25;
    logic signed [31:0] a80;
    logic [31:0]        amag;
    logic [24:0]        gabs, labs, nabs;
    logic [29:0]        adend, gdend;
    logic [52:0]        rem_sh, rem_sub;
    logic               div_ge;
    logic [28:0]        srem_sh, trial, srem_sub;
    logic               sq_ge;
    logic signed [23:0] qval;
    logic signed [41:0] sprod, vr;
    logic               s_acc, cfg_we;

    imm_smul u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .p       (mul_p)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign cfg_we   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == imm_pkg::REG_GAIN) ? {16'b0, gain_reg} : 32'b0;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    // per-axis arithmetic, divider step and square-root step
    always_comb begin
        a_sel    = a_reg[ax_reg];
        g_sel    = g_reg[ax_reg];
        asum_sel = asum_reg[ax_reg];
        gsum_sel = gsum_reg[ax_reg];
        acc_sel  = acc_reg[ax_reg];
        lp_sel   = lp_reg[ax_reg];
        aprod    = a_sel * N_S;
        gprod    = g_sel * N_S;
        adiff    = aprod - 25'(asum_sel);
        gdiff    = gprod - 25'(gsum_sel);
        a80      = (32'(adiff) <<< 6) + (32'(adiff) <<< 4);
        amag     = a80[31] ? 32'(-a80) : 32'(a80);
        adend    = amag[29:0] + HALF_N;
        gabs     = gdiff[24] ? 25'(-gdiff) : 25'(gdiff);
        gdend    = {5'b0, gabs} + HALF_G;
        ldiff    = 25'(lp_sel) - 25'(acc_sel);
        labs     = ldiff[24] ? 25'(-ldiff) : 25'(ldiff);
        net25    = 25'(acc_sel) - 25'(lpn_reg);
        nabs     = net25[24] ? 25'(-net25) : 25'(net25);
        qval     = sgn_reg ? -$signed({1'b0, quo_reg[22:0]}) : $signed({1'b0, quo_reg[22:0]});
        sprod    = dsign_reg ? -$signed({2'b0, mul_p[39:0]}) : $signed({2'b0, mul_p[39:0]});
        vr       = v_reg + (v_reg[41] ? 42'sd32767 : 42'sd32768);
        rem_sh   = {rem_reg, dvd_reg[79]};
        div_ge   = rem_sh >= {1'b0, den_reg};
        rem_sub  = rem_sh - {1'b0, den_reg};
        srem_sh  = {srem_reg, sqv_reg[49:48]};
        trial    = {2'b0, root_reg, 2'b01};
        sq_ge    = srem_sh >= trial;
        srem_sub = srem_sh - trial;
    end

    // multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_LPSET) begin
            mul_a = 96'(labs[23:0]);
            mul_b = 48'(gain_reg);
        end else begin
            case (mstep_reg)
                4'd0: begin
                    mul_a = 96'(netm_reg[0]);
                    mul_b = 48'(netm_reg[0]);
                end
                4'd1: begin
                    mul_a = 96'(netm_reg[2]);
                    mul_b = 48'(netm_reg[2]);
                end
                4'd2: begin
                    mul_a = 96'(gmag_reg[0]);
                    mul_b = 48'(gmag_reg[0]);
                end
                4'd3: begin
                    mul_a = 96'(t_reg);
                    mul_b = 48'(gmag_reg[0]);
                end
                4'd4: begin
                    mul_a = 96'(gmag_reg[1]);
                    mul_b = 48'(gmag_reg[1]);
                end
                4'd5: begin
                    mul_a = 96'(gmag_reg[2]);
                    mul_b = 48'(gmag_reg[2]);
                end
                4'd6: begin
                    mul_a = 96'(d_reg);
                    mul_b = 48'(26'(root_reg) + 26'd65536);
                end
                4'd7: begin
                    mul_a = 96'(netm_reg[1]);
                    mul_b = 48'(netm_reg[1]);
                end
                4'd8: begin
                    mul_a = 96'(y2_reg);
                    mul_b = y2_reg;
                end
                4'd9: begin
                    mul_a = y4_reg;
                    mul_b = y2_reg;
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    always_comb begin
        state_next  = state_reg;
        gain_next   = gain_reg;
        calib_next  = calib_reg;
        asum_next   = asum_reg;
        gsum_next   = gsum_reg;
        lp_next     = lp_reg;
        a_next      = a_reg;
        g_next      = g_reg;
        acc_next    = acc_reg;
        gmag_next   = gmag_reg;
        netm_next   = netm_reg;
        ax_next     = ax_reg;
        dsign_next  = dsign_reg;
        sgn_next    = sgn_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        qsat_next   = qsat_reg;
        cnt_next    = cnt_reg;
        v_next      = v_reg;
        lpn_next    = lpn_reg;
        mstep_next  = mstep_reg;
        sq_next     = sq_reg;
        t_next      = t_reg;
        d_next      = d_reg;
        y2_next     = y2_reg;
        y4_next     = y4_reg;
        sqv_next    = sqv_reg;
        srem_next   = srem_reg;
        root_next   = root_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        mul_start   = 1'b0;

        if (cfg_we && paddr[2] == imm_pkg::REG_GAIN) begin
            gain_next = pwdata[15:0];
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (calib_reg < CAL_N) begin
                        for (int i = 0; i < 3; i++) begin
                            asum_next[i] = asum_reg[i] + 24'($signed(s_tdata[16*i +: 16]));
                            gsum_next[i] = gsum_reg[i] + 24'($signed(s_tdata[16*i+48 +: 16]));
                        end
                        calib_next = calib_reg + 1'b1;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            a_next[i] = $signed(s_tdata[16*i +: 16]);
                            g_next[i] = $signed(s_tdata[16*i+48 +: 16]);
                        end
                        ax_next    = 2'd0;
                        state_next = ST_ASET;
                    end
                end
            end
            ST_ASET: begin
                dvd_next   = {adend, 50'b0};
                rem_next   = '0;
                den_next   = DEN_N;
                cnt_next   = imm_pkg::DIV_SMALL_STEPS;
                sgn_next   = a80[31];
                state_next = ST_ADIV;
            end
            ST_ADIV, ST_GDIV, ST_BDIV: begin
                rem_next  = div_ge ? rem_sub[51:0] : rem_sh[51:0];
                quo_next  = {quo_reg[54:0], div_ge};
                qsat_next = qsat_reg | quo_reg[55];
                dvd_next  = {dvd_reg[78:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == 7'd1) begin
                    case (state_reg)
                        ST_ADIV: state_next = ST_GSET;
                        ST_GDIV: state_next = ST_LPSET;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_GSET: begin
                acc_next[ax_reg] = (ax_reg == 2'd2) ? qval + imm_pkg::Z_REF : qval;
                dvd_next   = {gdend, 50'b0};
                rem_next   = '0;
                den_next   = DEN_G;
                cnt_next   = imm_pkg::DIV_SMALL_STEPS;
                state_next = ST_GDIV;
            end
            ST_LPSET: begin
                gmag_next[ax_reg] = quo_reg[8:0];
                dsign_next = ldiff[24];
                mul_start  = 1'b1;
                state_next = ST_LPMUL;
            end
            ST_LPMUL: begin
                if (!mul_busy) begin
                    v_next     = (42'(acc_sel) <<< 16) + sprod;
                    state_next = ST_LPR;
                end
            end
            ST_LPR: begin
                lp_next[ax_reg] = vr[39:16];
                lpn_next   = vr[39:16];
                state_next = ST_NET;
            end
            ST_NET: begin
                netm_next[ax_reg] = nabs[23:0];
                if (ax_reg == 2'd2) begin
                    mstep_next = 4'd0;
                    state_next = ST_MSET;
                end else begin
                    ax_next    = ax_reg + 1'b1;
                    state_next = ST_ASET;
                end
            end
            ST_MSET: begin
                mul_start  = 1'b1;
                state_next = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (!mul_busy) begin
                    mstep_next = mstep_reg + 1'b1;
                    state_next = ST_MSET;
                    case (mstep_reg)
                        4'd0: sq_next = mul_p[47:0];
                        4'd1: begin
                            sqv_next   = 50'(sq_reg) + 50'(mul_p[47:0]);
                            srem_next  = '0;
                            root_next  = '0;
                            cnt_next   = imm_pkg::SQRT_STEPS;
                            state_next = ST_SQRT;
                        end
                        4'd2: t_next = mul_p[17:0];
                        4'd3: d_next = 27'd1 + mul_p[26:0];
                        4'd4, 4'd5: d_next = d_reg + 27'(mul_p[17:0]);
                        4'd6: den_next = mul_p[51:0];
                        4'd7: y2_next = mul_p[47:0];
                        4'd8: y4_next = mul_p[95:0];
                        4'd9: begin
                            dvd_next   = mul_p[143:64];
                            rem_next   = '0;
                            quo_next   = '0;
                            qsat_next  = 1'b0;
                            cnt_next   = imm_pkg::DIV_BIG_STEPS;
                            state_next = ST_BDIV;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SQRT: begin
                srem_next = sq_ge ? srem_sub[26:0] : srem_sh[26:0];
                root_next = {root_reg[23:0], sq_ge};
                sqv_next  = {sqv_reg[47:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == 7'd1) begin
                    state_next = ST_MSET;
                end
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = qsat_reg ? imm_pkg::METRIC_MAX : quo_reg;
                    muser_next  = qsat_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            gain_reg   <= imm_pkg::GAIN_RESET;
            calib_reg  <= '0;
            mvalid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                asum_reg[i] <= '0;
                gsum_reg[i] <= '0;
                lp_reg[i]   <= '0;
            end
        end else begin
            state_reg  <= state_next;
            gain_reg   <= gain_next;
            calib_reg  <= calib_next;
            mvalid_reg <= mvalid_next;
            asum_reg   <= asum_next;
            gsum_reg   <= gsum_next;
            lp_reg     <= lp_next;
        end
        a_reg     <= a_next;
        g_reg     <= g_next;
        acc_reg   <= acc_next;
        gmag_reg  <= gmag_next;
        netm_reg  <= netm_next;
        ax_reg    <= ax_next;
        dsign_reg <= dsign_next;
        sgn_reg   <= sgn_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        quo_reg   <= quo_next;
        qsat_reg  <= qsat_next;
        cnt_reg   <= cnt_next;
        v_reg     <= v_next;
        lpn_reg   <= lpn_next;
        mstep_reg <= mstep_next;
        sq_reg    <= sq_next;
        t_reg     <= t_next;
        d_reg     <= d_next;
        y2_reg    <= y2_next;
        y4_reg    <= y4_next;
        sqv_reg   <= sqv_next;
        srem_reg  <= srem_next;
        root_reg  <= root_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

endmodule

>>> sv/imm_checker.sv
// ----------------------------------------------------------------------------
// imm_checker
// port-level checks of the imu motion metric block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "imu_motion_metric_macros.svh"

module imm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [imm_pkg::METRIC_W-1:0]  m_tdata,
    input logic                          m_tuser
);

    `IMM_ASSERT_RUN(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result item dropped or changed while stalled")
    `IMM_ASSERT_RUN(a_sat_clamp, m_tvalid && m_tuser |-> m_tdata == imm_pkg::METRIC_MAX, "saturated item not clamped")
    `IMM_ASSERT_RUN(a_out_after_work, $rose(m_tvalid) |-> $past(!s_tready), "result item without work in progress")
    `IMM_ASSERT_ALWAYS(a_rst_ready, !aresetn |=> s_tready && !m_tvalid, "not idle after reset")

endmodule

bind imu_motion_metric imm_checker u_imm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
